@@ src/assert_macros.svh @@
// Assertion macros used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication: cons must hold from the cycle after ante.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ src/dmtc_pkg.sv @@
// Types, sizes and helper functions for the 3D tile cache tag directory.
package dmtc_pkg;

    localparam int AXIS_SLOTS  = 8;
    localparam int COORD_BITS  = 16;
    localparam int AXIS_BITS   = $clog2(AXIS_SLOTS);
    localparam int SLOT_BITS   = 3 * AXIS_BITS;
    localparam int SLOT_COUNT  = AXIS_SLOTS * AXIS_SLOTS * AXIS_SLOTS;
    localparam int FIELD_W     = 16;
    localparam int SLOT_IDX_W  = 9;

    typedef logic [SLOT_BITS-1:0] t_slot;

    typedef struct packed {
        logic signed [FIELD_W-1:0] tile_x;
        logic signed [FIELD_W-1:0] tile_y;
        logic signed [FIELD_W-1:0] tile_z;
    } t_tile_req;

    typedef struct packed {
        logic                         hit;
        logic        [SLOT_IDX_W-1:0] slot_index;
        logic                         evict_valid;
        logic signed [FIELD_W-1:0]    evict_x;
        logic signed [FIELD_W-1:0]    evict_y;
        logic signed [FIELD_W-1:0]    evict_z;
    } t_tile_rsp;

    typedef struct packed {
        logic [COORD_BITS-1:0] cx;
        logic [COORD_BITS-1:0] cy;
        logic [COORD_BITS-1:0] cz;
    } t_coord3;

    typedef struct packed {
        logic    valid;
        t_coord3 coord;
    } t_tag_entry;

    typedef struct packed {
        logic       en;
        t_slot      addr;
        t_tag_entry entry;
    } t_tag_wr;

    // Keep the low COORD_BITS of each axis as the stored tag.
    function automatic t_coord3 coord_of(input t_tile_req req);
        t_coord3 c;
        c.cx = COORD_BITS'($unsigned(req.tile_x));
        c.cy = COORD_BITS'($unsigned(req.tile_y));
        c.cz = COORD_BITS'($unsigned(req.tile_z));
        return c;
    endfunction

    // Positive modulo by a power of two is just the low bits of each axis.
    function automatic t_slot slot_of(input t_coord3 c);
        return {c.cz[AXIS_BITS-1:0], c.cy[AXIS_BITS-1:0], c.cx[AXIS_BITS-1:0]};
    endfunction

endpackage

@@ src/direct_mapped_3d_tile_cache_tags.sv @@
// Top level of the direct-mapped 3D tile cache tag directory.
// One lookup per signed (x, y, z) tile coordinate: start with busy low transfers it, and
// o_done pulses for exactly one cycle, after the tag read and the result register, with the
// hit flag, the slot index and any evicted tile. A new lookup may be started every cycle
// while busy is low; the tag memory read is registered and the compare and update follow in
// the next cycle, with the last update forwarded so back-to-back lookups to the same slot
// see it. The result cannot be stalled, so it must be taken when o_done is high. After reset
// busy stays high while the tag memory is swept one slot per cycle to clear all valid bits.
`include "assert_macros.svh"

module direct_mapped_3d_tile_cache_tags import dmtc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_tile_req i_req,
    output logic      o_done,
    output t_tile_rsp o_result
);

    logic       accept;
    logic       clearing;
    t_tag_entry rd_data;
    t_tag_wr    wr;

    assign busy   = clearing;
    assign accept = start && !clearing;

    dmtc_tag_store u_tag_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (accept),
        .i_rd_addr  (slot_of(coord_of(i_req))),
        .o_rd_data  (rd_data),
        .i_wr       (wr),
        .o_clearing (clearing)
    );

    dmtc_lookup u_lookup (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_req     (i_req),
        .i_rd_data (rd_data),
        .o_wr      (wr),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    `ASSERT_NEXT(a_done_after_transfer, i_clk, i_rst_n, start && !busy, ##1 o_done)
    `ASSERT_IMPLY(a_hit_no_evict, i_clk, i_rst_n, o_done && o_result.hit, !o_result.evict_valid)
    `ASSERT_IMPLY(a_no_evict_zero, i_clk, i_rst_n, o_done && !o_result.evict_valid,
                  (o_result.evict_x | o_result.evict_y | o_result.evict_z) == '0)
    `ASSERT_IMPLY(a_no_tag_write_in_sweep, i_clk, i_rst_n, clearing, !wr.en)

endmodule

@@ src/dmtc_tag_store.sv @@
// Tag memory with registered read port and a valid-clearing sweep after reset.
module dmtc_tag_store import dmtc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rd_en,
    input  t_slot      i_rd_addr,
    output t_tag_entry o_rd_data,
    input  t_tag_wr    i_wr,
    output logic       o_clearing
);

    t_tag_entry r_mem [SLOT_COUNT];
    t_tag_entry r_rd_data;
    logic       r_clearing;
    t_slot      r_clr_addr;
    t_tag_wr    wr_sel;

    // Sweep every slot to invalid, one per cycle, before lookups start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + t_slot'(1);
            if (r_clr_addr == SLOT_BITS'(SLOT_COUNT - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_comb begin
        if (r_clearing) begin
            wr_sel.en    = 1'b1;
            wr_sel.addr  = r_clr_addr;
            wr_sel.entry = '0;
        end else begin
            wr_sel = i_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_sel.en) begin
            r_mem[wr_sel.addr] <= wr_sel.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data  = r_rd_data;
    assign o_clearing = r_clearing;

endmodule

@@ src/dmtc_lookup.sv @@
// Tag compare stage: forwarding, hit/evict decision, tag update and result register.
module dmtc_lookup import dmtc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_tile_req  i_req,
    input  t_tag_entry i_rd_data,
    output t_tag_wr    o_wr,
    output logic       o_done,
    output t_tile_rsp  o_result
);

    logic       r_s1_valid;
    t_coord3    r_s1_coord;
    t_slot      r_s1_slot;
    logic       r_fwd_valid;
    t_tag_entry r_fwd_entry;
    logic       r_done;
    t_tile_rsp  r_result;

    t_coord3    in_coord;
    t_slot      in_slot;
    t_tag_entry cur_entry;
    logic       hit;
    logic       evict;
    t_tile_rsp  n_result;

    assign in_coord = coord_of(i_req);
    assign in_slot  = slot_of(in_coord);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_s1_valid  <= i_accept;
            // The memory read at this edge misses the write from the item ahead.
            r_fwd_valid <= r_s1_valid && (r_s1_slot == in_slot);
            r_done      <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_coord <= in_coord;
            r_s1_slot  <= in_slot;
        end
        r_fwd_entry.valid <= 1'b1;
        r_fwd_entry.coord <= r_s1_coord;
        r_result          <= n_result;
    end

    always_comb begin
        cur_entry = r_fwd_valid ? r_fwd_entry : i_rd_data;
        hit       = cur_entry.valid && (cur_entry.coord == r_s1_coord);
        evict     = cur_entry.valid && !hit;

        n_result.hit         = hit;
        n_result.slot_index  = SLOT_IDX_W'(r_s1_slot);
        n_result.evict_valid = evict;
        n_result.evict_x     = evict ? FIELD_W'(cur_entry.coord.cx) : '0;
        n_result.evict_y     = evict ? FIELD_W'(cur_entry.coord.cy) : '0;
        n_result.evict_z     = evict ? FIELD_W'(cur_entry.coord.cz) : '0;

        o_wr.en          = r_s1_valid && !hit;
        o_wr.addr        = r_s1_slot;
        o_wr.entry.valid = 1'b1;
        o_wr.entry.coord = r_s1_coord;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ bench/tb_top.sv @@
// Self-checking testbench for the direct-mapped 3D tile cache tag directory.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dmtc_pkg::*;

    localparam int TAG_W = 3 * COORD_BITS;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start;
    logic      busy;
    t_tile_req i_req;
    logic      o_done;
    t_tile_rsp o_result;

    // Mirror of the tag directory and the lookups still waiting for a result.
    bit             tile_valid [SLOT_COUNT];
    logic [TAG_W-1:0] tile_tag [SLOT_COUNT];
    t_tile_rsp      expected_lookups [$];
    t_tile_req      recent_tiles [32];
    int             error_count = 0;
    int             burst_left = 0;

    direct_mapped_3d_tile_cache_tags u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_req    (i_req),
        .o_done   (o_done),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_tile_req make_tile(input int x, input int y, input int z);
        t_tile_req t;
        t.tile_x = 16'(x);
        t.tile_y = 16'(y);
        t.tile_z = 16'(z);
        return t;
    endfunction

    function automatic t_tile_req random_tile();
        t_tile_req t;
        t.tile_x = 16'($urandom);
        t.tile_y = 16'($urandom);
        t.tile_z = 16'($urandom);
        return t;
    endfunction

    // Look the tile up in the mirror, update it on a miss and return the lookup result.
    function automatic t_tile_rsp predict_lookup(input t_tile_req r);
        t_tile_rsp        rsp;
        logic [TAG_W-1:0] tag;
        int unsigned      slot;
        tag  = {r.tile_x[COORD_BITS-1:0], r.tile_y[COORD_BITS-1:0], r.tile_z[COORD_BITS-1:0]};
        // Positive modulo by a power of two keeps the low bits, negatives included.
        slot = r.tile_x[AXIS_BITS-1:0]
             + AXIS_SLOTS * r.tile_y[AXIS_BITS-1:0]
             + AXIS_SLOTS * AXIS_SLOTS * r.tile_z[AXIS_BITS-1:0];
        rsp = '0;
        rsp.slot_index = SLOT_IDX_W'(slot);
        rsp.hit = tile_valid[slot] && (tile_tag[slot] == tag);
        if (!rsp.hit) begin
            if (tile_valid[slot]) begin
                rsp.evict_valid = 1'b1;
                rsp.evict_x = tile_tag[slot][TAG_W-1 -: COORD_BITS];
                rsp.evict_y = tile_tag[slot][2*COORD_BITS-1 -: COORD_BITS];
                rsp.evict_z = tile_tag[slot][COORD_BITS-1:0];
            end
            tile_tag[slot]   = tag;
            tile_valid[slot] = 1'b1;
        end
        return rsp;
    endfunction

    // Drop start for a random gap, or hold it high through a burst.
    task automatic pause_between_lookups();
        int pick;
        int gap;
        if (burst_left > 0) begin
            burst_left--;
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            burst_left = $urandom_range(10, 50);
            return;
        end
        if (pick < 55)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(6, 30);
        if (gap > 0) begin
            start = 1'b0;
            i_req = random_tile();
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // Called just after a falling edge; returns just after a falling edge.
    task automatic send_lookup(input t_tile_req r);
        start = 1'b1;
        i_req = r;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_lookups.push_back(predict_lookup(r));
        @(negedge i_clk);
        pause_between_lookups();
    endtask

    task automatic check_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_tile_rsp want;
        if (i_rst_n === 1'b1 && o_done === 1'b1) begin
            if (expected_lookups.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, o_result);
                error_count++;
            end else begin
                want = expected_lookups.pop_front();
                check_field("hit", want.hit, o_result.hit);
                check_field("slot_index", want.slot_index, o_result.slot_index);
                check_field("evict_valid", want.evict_valid, o_result.evict_valid);
                check_field("evict_x", want.evict_x, o_result.evict_x);
                check_field("evict_y", want.evict_y, o_result.evict_y);
                check_field("evict_z", want.evict_z, o_result.evict_z);
            end
        end
    end

    // Hits, misses into empty slots, evictions, negative and extreme coordinates.
    task automatic test_corner_tiles();
        burst_left = 6;
        send_lookup(make_tile(0, 0, 0));
        send_lookup(make_tile(0, 0, 0));
        send_lookup(make_tile(-1, -1, -1));
        send_lookup(make_tile(-1, -1, -1));
        send_lookup(make_tile(32767, 32767, 32767));
        send_lookup(make_tile(-32768, -32768, -32768));
        send_lookup(make_tile(8, 16, -8));
        send_lookup(make_tile(0, 0, 0));
        send_lookup(make_tile(1, 2, 3));
        send_lookup(make_tile(9, 2, 3));
        send_lookup(make_tile(9, 2, 3));
        send_lookup(make_tile(-7, 0, 0));
        send_lookup(make_tile(1, 0, 0));
        send_lookup(make_tile(32767, -32768, 0));
        send_lookup(make_tile(-32768, 32767, 5));
        send_lookup(make_tile(21845, -21846, 21845));
        send_lookup(make_tile(-21846, 21845, -21846));
        send_lookup(make_tile(0, 0, 0));
    endtask

    // Back-to-back lookups into one slot so the update forwarding is exercised.
    task automatic test_slot_conflicts();
        t_tile_req base;
        t_tile_req t;
        base = random_tile();
        burst_left = 40;
        repeat (40) begin
            t = base;
            t.tile_x[FIELD_W-1:AXIS_BITS] = (FIELD_W-AXIS_BITS)'($urandom_range(0, 2));
            t.tile_y[FIELD_W-1:AXIS_BITS] = (FIELD_W-AXIS_BITS)'($urandom_range(0, 1));
            send_lookup(t);
        end
    endtask

    // Mix of repeats, same-slot replacements, a crowded region and fully random tiles.
    task automatic test_random_traffic(input int count);
        t_tile_req t;
        int        pick;
        int        k;
        foreach (recent_tiles[i])
            recent_tiles[i] = make_tile($urandom_range(0, 23) - 12, $urandom_range(0, 23) - 12,
                                        $urandom_range(0, 23) - 12);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            k    = $urandom_range(0, 31);
            if (pick < 30) begin
                t = recent_tiles[k];
            end else if (pick < 55) begin
                t = recent_tiles[k];
                if ($urandom_range(0, 1)) begin
                    t.tile_x[FIELD_W-1:AXIS_BITS] = (FIELD_W-AXIS_BITS)'($urandom);
                    t.tile_z[FIELD_W-1:AXIS_BITS] = (FIELD_W-AXIS_BITS)'($urandom);
                end else begin
                    t.tile_y[FIELD_W-1:AXIS_BITS] = (FIELD_W-AXIS_BITS)'($urandom_range(0, 3));
                end
            end else if (pick < 75) begin
                t = make_tile($urandom_range(0, 23) - 12, $urandom_range(0, 23) - 12,
                              $urandom_range(0, 23) - 12);
            end else begin
                t = random_tile();
            end
            recent_tiles[$urandom_range(0, 31)] = t;
            send_lookup(t);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_req   = '0;
        foreach (tile_valid[i])
            tile_valid[i] = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_corner_tiles();
        test_slot_conflicts();
        test_random_traffic(900);

        start = 1'b0;
        while (expected_lookups.size() != 0)
            @(negedge i_clk);
        repeat (5) @(negedge i_clk);

        if (error_count == 0 && expected_lookups.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("Verification failed");
        $finish;
    end

endmodule

@@ direct_mapped_3d_tile_cache_tags.f @@
+incdir+src
src/dmtc_pkg.sv
src/dmtc_tag_store.sv
src/dmtc_lookup.sv
src/direct_mapped_3d_tile_cache_tags.sv
bench/tb_top.sv
